FILE: rtl/core/tlpq_pkg.sv
package tlpq_pkg;

    localparam int TAG_W   = 16;
    localparam int STAMP_W = 32;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic               urgent;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // a goes ahead of b: higher priority first, then strictly earlier stamp
    function automatic logic beats(entry_t a, entry_t b);
        logic res;
        if (a.urgent != b.urgent)
        begin
            res = a.urgent;
        end
        else
        begin
            res = (a.stamp < b.stamp);
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/tlpq_req_if.sv
interface tlpq_req_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [tlpq_pkg::TAG_W-1:0]   new_tag;
    logic                       new_urgent;
    logic [tlpq_pkg::STAMP_W-1:0] new_stamp;

    modport source (output valid, cmd, new_tag, new_urgent, new_stamp, input ready);
    modport sink   (input valid, cmd, new_tag, new_urgent, new_stamp, output ready);
endinterface

FILE: rtl/core/tlpq_rsp_if.sv
interface tlpq_rsp_if #(
    parameter int CNT_W = 5
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status_code;
    logic [tlpq_pkg::TAG_W-1:0]   out_tag;
    logic                         out_urgent;
    logic [tlpq_pkg::STAMP_W-1:0] out_stamp;
    logic [CNT_W-1:0]             fill_count;
    logic                         is_empty;

    modport source (output valid, status_code, out_tag, out_urgent, out_stamp, fill_count,
                    is_empty, input ready);
    modport sink   (input valid, status_code, out_tag, out_urgent, out_stamp, fill_count,
                    is_empty, output ready);
endinterface

FILE: rtl/core/two_level_priority_fifo_queue.sv
// Enqueue: S_CMP compares the new entry with stored entries from the tail toward the head;
// each entry that the new one beats is shifted back one place through the store, which has
// one read and one write port, then the new entry is written and the result passes S_OUT.
// Dequeue passes S_DEQ and S_OUT; a refused request goes straight to S_OUT. One request in
// flight at a time; the next is taken the cycle after the result moves to the output register.
// Reset clears state, head, count and the output valid; the entry store is not cleared.
module two_level_priority_fifo_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    tlpq_req_if.sink          req,
    tlpq_rsp_if.source        rsp
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_ZERO = '0;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_DEQ  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;

    tlpq_pkg::entry_t item_reg, item_next;
    tlpq_pkg::entry_t st_entry_reg, st_entry_next;
    logic [1:0]       st_status_reg, st_status_next;

    logic             ov_reg;
    logic [1:0]       o_status_reg;
    tlpq_pkg::entry_t o_entry_reg;
    logic [CNT_W-1:0] o_count_reg;

    logic             req_fire;
    logic             out_free;
    logic [IDX_W-1:0] rd_off;
    logic             wr_en;
    logic [IDX_W-1:0] wr_off;
    tlpq_pkg::entry_t wr_data;
    tlpq_pkg::entry_t rd_data;
    tlpq_pkg::entry_t req_entry;

    tlpq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk     (clk),
        .head    (head_reg),
        .rd_off  (rd_off),
        .wr_en   (wr_en),
        .wr_off  (wr_off),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !ov_reg || rsp.ready;

    always_comb
    begin
        req_entry.tag    = req.new_tag;
        req_entry.urgent = req.new_urgent;
        req_entry.stamp  = req.new_stamp;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        item_next      = item_reg;
        st_entry_next  = st_entry_reg;
        st_status_next = st_status_reg;
        rd_off         = IDX_ZERO;
        wr_en          = 1'b0;
        wr_off         = k_reg[IDX_W-1:0];
        wr_data        = item_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_off = (req.cmd == tlpq_pkg::CMD_ENQ) ?
                         IDX_W'(count_reg - CNT_ONE) : IDX_ZERO;
                if (req_fire)
                begin
                    item_next      = req_entry;
                    st_entry_next  = '0;
                    st_status_next = tlpq_pkg::ST_DONE;
                    k_next         = count_reg;
                    if (req.cmd == tlpq_pkg::CMD_ENQ)
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            st_status_next = tlpq_pkg::ST_FULL;
                            state_next     = S_OUT;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            st_status_next = tlpq_pkg::ST_EMPTY;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            state_next = S_DEQ;
                        end
                    end
                end
            end
            S_CMP:
            begin
                // rd_data holds the entry at offset k-1
                rd_off = IDX_W'(k_reg - CNT_TWO);
                wr_en  = 1'b1;
                if (tlpq_pkg::beats(item_reg, rd_data))
                begin
                    // shift the beaten entry back one place and keep scanning
                    wr_data = rd_data;
                    k_next  = k_reg - CNT_ONE;
                    if (k_reg == CNT_ONE)
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_ONE;
                    state_next = S_OUT;
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_ONE;
                state_next = S_OUT;
            end
            S_DEQ:
            begin
                st_entry_next = rd_data;
                head_next     = (head_reg == IDX_LAST) ? IDX_ZERO : head_reg + IDX_W'(1);
                count_next    = count_reg - CNT_ONE;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (state_reg == S_OUT && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        item_reg      <= item_next;
        st_entry_reg  <= st_entry_next;
        st_status_reg <= st_status_next;
        if (state_reg == S_OUT && out_free)
        begin
            o_status_reg <= st_status_reg;
            o_entry_reg  <= st_entry_reg;
            o_count_reg  <= count_reg;
        end
    end

    assign rsp.valid       = ov_reg;
    assign rsp.status_code = o_status_reg;
    assign rsp.out_tag     = o_entry_reg.tag;
    assign rsp.out_urgent  = o_entry_reg.urgent;
    assign rsp.out_stamp   = o_entry_reg.stamp;
    assign rsp.fill_count  = o_count_reg;
    assign rsp.is_empty    = (o_count_reg == '0);

endmodule

FILE: rtl/core/tlpq_store.sv
module tlpq_store #(
    parameter int QUEUE_DEPTH = 16,
    parameter int IDX_W       = 4
) (
    input  logic                 clk,
    input  logic [IDX_W-1:0]     head,
    input  logic [IDX_W-1:0]     rd_off,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_off,
    input  tlpq_pkg::entry_t     wr_data,
    output tlpq_pkg::entry_t     rd_data
);

    localparam logic [IDX_W:0] DEPTH_W = (IDX_W+1)'(QUEUE_DEPTH);

    tlpq_pkg::entry_t mem [QUEUE_DEPTH];
    tlpq_pkg::entry_t rd_data_reg;

    logic [IDX_W:0]   rd_sum;
    logic [IDX_W:0]   wr_sum;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    // wrap offsets around the ring; for an offset below the depth the sum stays below twice the depth
    always_comb
    begin
        rd_sum = {1'b0, head} + {1'b0, rd_off};
        wr_sum = {1'b0, head} + {1'b0, wr_off};
        rd_addr = (rd_sum >= DEPTH_W) ? IDX_W'(rd_sum - DEPTH_W) : rd_sum[IDX_W-1:0];
        wr_addr = (wr_sum >= DEPTH_W) ? IDX_W'(wr_sum - DEPTH_W) : wr_sum[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/sv/two_level_priority_fifo_queue_tb.sv
`timescale 1ns / 1ps

module two_level_priority_fifo_queue_tb;

    localparam int DEPTH        = 16;
    localparam int CNT_W        = 5;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int DRAIN_LIMIT  = 5000;

    typedef struct {
        logic [1:0]                   status;
        logic [tlpq_pkg::TAG_W-1:0]   tag;
        logic                         urgent;
        logic [tlpq_pkg::STAMP_W-1:0] stamp;
        logic [CNT_W-1:0]             fill;
        logic                         empty;
    } queue_outcome_t;

    logic clk;
    logic rst_n;

    tlpq_req_if                   req_bus ();
    tlpq_rsp_if #(.CNT_W(CNT_W))  rsp_bus ();

    two_level_priority_fifo_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    tlpq_pkg::entry_t held_entries[$];
    queue_outcome_t   awaited_outcomes[$];
    int               error_count;
    int               hold_off_left;
    bit               sender_gaps;
    bit               receiver_stalls;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_error(input string msg);
        begin
            $display("[%0t] mismatch: %s", $time, msg);
            error_count++;
        end
    endtask

    // a is served before b: urgent first, then strictly earlier stamp
    function automatic bit ranks_ahead(tlpq_pkg::entry_t a, tlpq_pkg::entry_t b);
        return {a.urgent, ~a.stamp} > {b.urgent, ~b.stamp};
    endfunction

    task automatic predict_outcome(input logic c, input logic [tlpq_pkg::TAG_W-1:0] tag,
                                   input logic urg,
                                   input logic [tlpq_pkg::STAMP_W-1:0] stamp);
        tlpq_pkg::entry_t fresh;
        tlpq_pkg::entry_t head;
        queue_outcome_t   o;
        int               slot;
        begin
            o = '{status: tlpq_pkg::ST_DONE, tag: '0, urgent: 1'b0, stamp: '0,
                  fill: '0, empty: 1'b0};
            if (c == tlpq_pkg::CMD_ENQ)
            begin
                if (held_entries.size() >= DEPTH)
                begin
                    o.status = tlpq_pkg::ST_FULL;
                end
                else
                begin
                    fresh.tag    = tag;
                    fresh.urgent = urg;
                    fresh.stamp  = stamp;
                    slot = held_entries.size();
                    for (int k = 0; k < held_entries.size(); k++)
                    begin
                        if (ranks_ahead(fresh, held_entries[k]))
                        begin
                            slot = k;
                            break;
                        end
                    end
                    held_entries.insert(slot, fresh);
                end
            end
            else
            begin
                if (held_entries.size() == 0)
                begin
                    o.status = tlpq_pkg::ST_EMPTY;
                end
                else
                begin
                    head     = held_entries.pop_front();
                    o.tag    = head.tag;
                    o.urgent = head.urgent;
                    o.stamp  = head.stamp;
                end
            end
            o.fill  = CNT_W'(held_entries.size());
            o.empty = (held_entries.size() == 0);
            awaited_outcomes.push_back(o);
        end
    endtask

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic c, input logic [tlpq_pkg::TAG_W-1:0] tag,
                                input logic urg,
                                input logic [tlpq_pkg::STAMP_W-1:0] stamp);
        int gap;
        begin
            if (sender_gaps && $urandom_range(99) < 6)
            begin
                gap = $urandom_range(6, 1);
                req_bus.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            req_bus.valid      = 1'b1;
            req_bus.cmd        = c;
            req_bus.new_tag    = tag;
            req_bus.new_urgent = urg;
            req_bus.new_stamp  = stamp;
            do
                @(posedge clk);
            while (req_bus.ready !== 1'b1);
            predict_outcome(c, tag, urg, stamp);
            @(negedge clk);
            req_bus.valid = 1'b0;
        end
    endtask

    function automatic logic [tlpq_pkg::STAMP_W-1:0] pick_stamp();
        logic [tlpq_pkg::STAMP_W-1:0] s;
        case ($urandom_range(3))
            0, 1:    s = $urandom_range(15);
            2:       s = $urandom;
            default: s = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3)
                                           : 32'(32'h8000_0000 + $urandom_range(3));
        endcase
        return s;
    endfunction

    task automatic send_random_enqueue();
        begin
            send_request(tlpq_pkg::CMD_ENQ, tlpq_pkg::TAG_W'($urandom_range(16'hFFFF)),
                         1'($urandom_range(1)), pick_stamp());
        end
    endtask

    task automatic send_dequeue();
        begin
            send_request(tlpq_pkg::CMD_DEQ, tlpq_pkg::TAG_W'($urandom),
                         1'($urandom_range(1)), $urandom);
        end
    endtask

    // change flags read by the falling-edge drivers away from that edge
    task automatic set_idling(input bit on);
        begin
            @(posedge clk);
            sender_gaps     = on;
            receiver_stalls = on;
            @(negedge clk);
        end
    endtask

    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                rsp_bus.ready = 1'b0;
                hold_off_left--;
            end
            else
            begin
                rsp_bus.ready = !receiver_stalls || ($urandom_range(99) >= 6);
            end
        end
    end

    always @(posedge clk)
    begin
        queue_outcome_t want;
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                report_error("result with no request outstanding");
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                if (rsp_bus.status_code !== want.status)
                    report_error($sformatf("status_code got %0h want %0h",
                                           rsp_bus.status_code, want.status));
                if (rsp_bus.out_tag !== want.tag)
                    report_error($sformatf("out_tag got %0h want %0h",
                                           rsp_bus.out_tag, want.tag));
                if (rsp_bus.out_urgent !== want.urgent)
                    report_error($sformatf("out_urgent got %0h want %0h",
                                           rsp_bus.out_urgent, want.urgent));
                if (rsp_bus.out_stamp !== want.stamp)
                    report_error($sformatf("out_stamp got %0h want %0h",
                                           rsp_bus.out_stamp, want.stamp));
                if (rsp_bus.fill_count !== want.fill)
                    report_error($sformatf("fill_count got %0d want %0d",
                                           rsp_bus.fill_count, want.fill));
                if (rsp_bus.is_empty !== want.empty)
                    report_error($sformatf("is_empty got %0h want %0h",
                                           rsp_bus.is_empty, want.empty));
            end
        end
    end

    task automatic test_empty_dequeue();
        begin
            send_dequeue();
            send_dequeue();
        end
    endtask

    // extremes of every field, urgent over normal, earlier stamp first, ties in order
    task automatic test_ordering_extremes();
        begin
            send_request(tlpq_pkg::CMD_ENQ, 16'h0000, 1'b0, 32'hFFFF_FFFF);
            send_request(tlpq_pkg::CMD_ENQ, 16'hFFFF, 1'b0, 32'h0000_0000);
            send_request(tlpq_pkg::CMD_ENQ, 16'h1234, 1'b1, 32'hFFFF_FFFF);
            send_request(tlpq_pkg::CMD_ENQ, 16'h5678, 1'b1, 32'hFFFF_FFFF);
            send_request(tlpq_pkg::CMD_ENQ, 16'h00FF, 1'b1, 32'h0000_0000);
            send_request(tlpq_pkg::CMD_ENQ, 16'hFF00, 1'b0, 32'h0000_0000);
            send_request(tlpq_pkg::CMD_ENQ, 16'hAAAA, 1'b0, 32'h8000_0000);
            send_request(tlpq_pkg::CMD_ENQ, 16'h5555, 1'b1, 32'h7FFF_FFFF);
            repeat (9) send_dequeue();
        end
    endtask

    // fill to capacity, push while full, then drain past empty
    task automatic test_full_queue();
        begin
            repeat (DEPTH) send_random_enqueue();
            send_random_enqueue();
            send_random_enqueue();
            send_dequeue();
            send_random_enqueue();
            send_random_enqueue();
            repeat (DEPTH + 1) send_dequeue();
        end
    endtask

    // segments with different push/pop balance keep the fill level moving
    task automatic test_random_mix(input int n_items);
        int bias;
        begin
            bias = 50;
            for (int i = 0; i < n_items; i++)
            begin
                if (i % 40 == 0)
                begin
                    case ($urandom_range(3))
                        0:       bias = 25;
                        1:       bias = 50;
                        2:       bias = 75;
                        default: bias = 90;
                    endcase
                end
                if ($urandom_range(99) < bias)
                    send_random_enqueue();
                else
                    send_dequeue();
            end
        end
    endtask

    task automatic test_backpressure();
        begin
            @(posedge clk);
            hold_off_left = 300;
            @(negedge clk);
            repeat (12) send_random_enqueue();
            repeat (6) send_dequeue();
            repeat (6) send_random_enqueue();
        end
    endtask

    task automatic test_back_to_back();
        begin
            set_idling(1'b0);
            test_random_mix(60);
            set_idling(1'b1);
        end
    endtask

    initial
    begin
        int drain_wait;
        error_count        = 0;
        hold_off_left      = 0;
        sender_gaps        = 1'b1;
        receiver_stalls    = 1'b1;
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.cmd        = tlpq_pkg::CMD_ENQ;
        req_bus.new_tag    = '0;
        req_bus.new_urgent = 1'b0;
        req_bus.new_stamp  = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_dequeue();
        test_ordering_extremes();
        test_full_queue();
        test_random_mix(200);
        test_backpressure();
        test_back_to_back();
        test_random_mix(160);
        req_bus.valid = 1'b0;

        drain_wait = 0;
        while (awaited_outcomes.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        if (awaited_outcomes.size() != 0)
            report_error($sformatf("%0d results never arrived", awaited_outcomes.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: two_level_priority_fifo_queue.f
rtl/core/tlpq_pkg.sv
rtl/core/tlpq_req_if.sv
rtl/core/tlpq_rsp_if.sv
rtl/core/tlpq_store.sv
rtl/core/two_level_priority_fifo_queue.sv
tb/sv/two_level_priority_fifo_queue_tb.sv
